@@ design/four_level_page_table_walker_assert.svh @@
// Assertion macros shared by the page table walker RTL.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PGW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PGW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/pgwalk_pkg.sv @@
package pgwalk_pkg;

    // Fixed table geometry: 512 entries of 64 bits, 9 index bits a level.
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = 9;
    localparam int ENTRY_W           = 64;
    localparam int PAGE_W            = 40;

    // Request codes.
    localparam logic [1:0] REQ_TRANSLATE = 2'd0;
    localparam logic [1:0] REQ_MAP       = 2'd1;
    localparam logic [1:0] REQ_UNMAP     = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ABSENT  = 2'd1;
    localparam logic [1:0] ST_NOFRAME = 2'd2;
    localparam logic [1:0] ST_OUTSIDE = 2'd3;

    // Configuration port.
    localparam int              PADDR_W         = 4;
    localparam int              PDATA_W         = 64;
    localparam logic            REG_TABLE_BASE  = 1'b0;
    localparam logic [PAGE_W-1:0] TABLE_BASE_RESET = 40'd256;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [47:0] virt_addr;
        logic [51:0] phys_addr_in;
        logic [27:0] map_flags;
    } pgwalk_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [51:0] phys_addr_out;
    } pgwalk_rsp_t;

endpackage

@@ design/pgwalk_ram.sv @@
module pgwalk_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/four_level_page_table_walker.sv @@
// Channel   Direction  Handshake             Payload
// request   in         req_valid/req_stall   req_data  (pgwalk_req_t)
// response  out        rsp_valid/rsp_stall   rsp_data  (pgwalk_rsp_t)
// config    in         APB psel/penable      paddr, pwdata, prdata (40-bit table base)
//
// A translate or unmap takes one table store read and one evaluation step per level
// (four levels).
// A map takes the same, plus the clear of every table frame it allocates and its link write.
// After reset the TABLE_FRAMES*512 entries of the table store are cleared one entry a cycle,
// and no request is accepted meanwhile; configuration writes are taken.
// A finished response waits in an output register while the next request is accepted.
module four_level_page_table_walker #(
    parameter int TABLE_FRAMES = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  pgwalk_pkg::pgwalk_req_t              req_data,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output pgwalk_pkg::pgwalk_rsp_t              rsp_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pgwalk_pkg::PADDR_W-1:0]       paddr,
    input  logic [pgwalk_pkg::PDATA_W-1:0]       pwdata,
    output logic [pgwalk_pkg::PDATA_W-1:0]       prdata,
    output logic                                 pready
);

`include "four_level_page_table_walker_assert.svh"

    localparam int DEPTH   = TABLE_FRAMES * pgwalk_pkg::ENTRIES_PER_TABLE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int FRAME_W = $clog2(TABLE_FRAMES);
    localparam int NFF_W   = $clog2(TABLE_FRAMES + 1);
    localparam int IDX_W   = pgwalk_pkg::IDX_W;
    localparam int PAGE_W  = pgwalk_pkg::PAGE_W;
    localparam int ENTRY_W = pgwalk_pkg::ENTRY_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_ZERO,
        S_LINK,
        S_RESP
    } state_t;

    // Control registers.
    state_t              state_reg,     state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg,   clr_cnt_next;
    logic [IDX_W-1:0]    zero_cnt_reg,  zero_cnt_next;
    logic [1:0]          level_reg,     level_next;
    logic [FRAME_W-1:0]  frame_reg,     frame_next;
    logic [NFF_W-1:0]    nff_reg,       nff_next;
    logic [PAGE_W-1:0]   base_reg,      base_next;
    logic                rsp_valid_reg, rsp_valid_next;

    // Payload registers.
    pgwalk_pkg::pgwalk_req_t req_reg,   req_next;
    pgwalk_pkg::pgwalk_rsp_t rsp_reg,   rsp_next;
    logic [FRAME_W-1:0]      new_frame_reg, new_frame_next;
    logic [ENTRY_W-1:0]      link_reg,  link_next;
    logic [1:0]              status_reg, status_next;
    logic [51:0]             pa_reg,    pa_next;

    // Table store ports.
    logic               mem_wr_en;
    logic [ADDR_W-1:0]  mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;
    logic [ADDR_W-1:0]  mem_rd_addr;
    logic [ENTRY_W-1:0] mem_rd_data;

    // Datapath values.
    logic [IDX_W-1:0]   idx_cur;
    logic [ADDR_W-1:0]  slot_addr;
    logic [PAGE_W-1:0]  frame_delta;
    logic               outside;
    logic               nff_full;
    logic [ENTRY_W-1:0] upper_flags;
    logic [ENTRY_W-1:0] leaf_entry;
    logic [PAGE_W-1:0]  new_page;
    logic               cfg_write;

    pgwalk_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Index of the current level taken from the virtual address.
    always_comb
    begin
        case (level_reg)
            2'd3:    idx_cur = req_reg.virt_addr[39 +: IDX_W];
            2'd2:    idx_cur = req_reg.virt_addr[30 +: IDX_W];
            2'd1:    idx_cur = req_reg.virt_addr[21 +: IDX_W];
            default: idx_cur = req_reg.virt_addr[12 +: IDX_W];
        endcase
    end

    assign slot_addr   = {frame_reg, idx_cur};
    assign mem_rd_addr = slot_addr;

    // Resolve the frame that the entry just read points to.
    assign frame_delta = mem_rd_data[12 +: PAGE_W] - base_reg;
    assign outside     = frame_delta >= PAGE_W'(TABLE_FRAMES);
    assign nff_full    = nff_reg >= NFF_W'(TABLE_FRAMES);
    assign new_page    = base_reg + PAGE_W'(nff_reg);

    // Flag bits for upper entries and the full leaf entry.
    assign upper_flags = {1'b0, req_reg.map_flags[26:16], 40'd0, req_reg.map_flags[11:0]};
    assign leaf_entry  = {req_reg.map_flags[27:16], req_reg.phys_addr_in[51:12],
                          req_reg.map_flags[11:0]};

    // Configuration register port.
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[3] == pgwalk_pkg::REG_TABLE_BASE)
                       ? {{(pgwalk_pkg::PDATA_W - PAGE_W){1'b0}}, base_reg} : '0;

    // Sequencer: reset clear, level walk, frame clear, link write, response.
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        zero_cnt_next  = zero_cnt_reg;
        level_next     = level_reg;
        frame_next     = frame_reg;
        nff_next       = nff_reg;
        base_next      = base_reg;
        rsp_valid_next = rsp_valid_reg;
        req_next       = req_reg;
        rsp_next       = rsp_reg;
        new_frame_next = new_frame_reg;
        link_next      = link_reg;
        status_next    = status_reg;
        pa_next        = pa_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = slot_addr;
        mem_wr_data    = '0;

        if (cfg_write && (paddr[3] == pgwalk_pkg::REG_TABLE_BASE))
        begin
            base_next = pwdata[PAGE_W-1:0];
        end

        // The response register empties when the receiver takes the response.
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next    = req_data;
                    level_next  = 2'd3;
                    frame_next  = '0;
                    status_next = pgwalk_pkg::ST_OK;
                    pa_next     = '0;
                    if (req_data.req_type == pgwalk_pkg::REQ_TRANSLATE ||
                        req_data.req_type == pgwalk_pkg::REQ_MAP ||
                        req_data.req_type == pgwalk_pkg::REQ_UNMAP)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end

            S_READ:
            begin
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                if (level_reg != 2'd0)
                begin
                    if (req_reg.req_type == pgwalk_pkg::REQ_MAP)
                    begin
                        if (!mem_rd_data[0])
                        begin
                            // Missing upper entry: allocate and clear a new frame, or report no frame if none is free.
                            if (nff_full)
                            begin
                                status_next = pgwalk_pkg::ST_NOFRAME;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                new_frame_next = nff_reg[FRAME_W-1:0];
                                nff_next       = nff_reg + 1'b1;
                                link_next      = upper_flags | {12'd0, new_page, 12'd1};
                                zero_cnt_next  = '0;
                                state_next     = S_ZERO;
                            end
                        end
                        else
                        begin
                            // Existing upper entry gets the flags ORed in.
                            mem_wr_en   = 1'b1;
                            mem_wr_data = mem_rd_data | upper_flags;
                            if (outside)
                            begin
                                status_next = pgwalk_pkg::ST_OUTSIDE;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                frame_next = frame_delta[FRAME_W-1:0];
                                level_next = level_reg - 1'b1;
                                state_next = S_READ;
                            end
                        end
                    end
                    else if (!mem_rd_data[0])
                    begin
                        status_next = pgwalk_pkg::ST_ABSENT;
                        state_next  = S_RESP;
                    end
                    else if (outside)
                    begin
                        status_next = pgwalk_pkg::ST_OUTSIDE;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        frame_next = frame_delta[FRAME_W-1:0];
                        level_next = level_reg - 1'b1;
                        state_next = S_READ;
                    end
                end
                else
                begin
                    // Leaf level.
                    state_next = S_RESP;
                    case (req_reg.req_type)
                        pgwalk_pkg::REQ_TRANSLATE:
                        begin
                            if (!mem_rd_data[0])
                            begin
                                status_next = pgwalk_pkg::ST_ABSENT;
                            end
                            else
                            begin
                                pa_next = {mem_rd_data[51:12], req_reg.virt_addr[11:0]};
                            end
                        end
                        pgwalk_pkg::REQ_MAP:
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_data = leaf_entry;
                        end
                        default:
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_data = '0;
                        end
                    endcase
                end
            end

            S_ZERO:
            begin
                mem_wr_en     = 1'b1;
                mem_wr_addr   = {new_frame_reg, zero_cnt_reg};
                mem_wr_data   = '0;
                zero_cnt_next = zero_cnt_reg + 1'b1;
                if (zero_cnt_reg == IDX_W'(pgwalk_pkg::ENTRIES_PER_TABLE - 1))
                begin
                    state_next = S_LINK;
                end
            end

            S_LINK:
            begin
                // The link is written after the clear, in case it lies in the new frame.
                mem_wr_en   = 1'b1;
                mem_wr_data = link_reg;
                frame_next  = new_frame_reg;
                level_next  = level_reg - 1'b1;
                state_next  = S_READ;
            end

            S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status        = status_reg;
                    rsp_next.phys_addr_out = pa_reg;
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            zero_cnt_reg  <= '0;
            level_reg     <= 2'd3;
            frame_reg     <= '0;
            nff_reg       <= NFF_W'(1);
            base_reg      <= pgwalk_pkg::TABLE_BASE_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            zero_cnt_reg  <= zero_cnt_next;
            level_reg     <= level_next;
            frame_reg     <= frame_next;
            nff_reg       <= nff_next;
            base_reg      <= base_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        rsp_reg       <= rsp_next;
        new_frame_reg <= new_frame_next;
        link_reg      <= link_next;
        status_reg    <= status_next;
        pa_reg        <= pa_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // The allocator never moves past the last frame.
    `PGW_ASSERT_SAME(a_nff_bound, 1'b1, 32'(nff_reg) <= TABLE_FRAMES,
        "frame allocator ran past the table store")

    // The walk only ever addresses frames inside the store.
    `PGW_ASSERT_SAME(a_frame_bound, 1'b1, 32'(frame_reg) < TABLE_FRAMES,
        "walk frame outside the table store")

    // An accepted request always starts work before the block is ready again.
    `PGW_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, req_stall,
        "block ready again right after accepting a request")

    // Clearing a newly allocated frame writes zeros every cycle.
    `PGW_ASSERT_SAME(a_zero_write, state_reg == S_ZERO, mem_wr_en && (mem_wr_data == '0),
        "frame clear does not write zero")

endmodule
